// ===== src/mwt_pkg.sv =====
// package: request and result codes for the memory watch table
`timescale 1ns / 1ps
`default_nettype none
package mwt_pkg;
  localparam logic [2:0] REQ_TICK = 3'd0;
  localparam logic [2:0] REQ_ADD = 3'd1;
  localparam logic [2:0] REQ_FREE = 3'd2;
  localparam logic [2:0] REQ_FREE_OWNER = 3'd3;
  localparam logic [2:0] REQ_SAMPLE = 3'd4;

  localparam logic [2:0] RES_NONE = 3'd0;
  localparam logic [2:0] RES_ADDED = 3'd1;
  localparam logic [2:0] RES_REJECTED = 3'd2;
  localparam logic [2:0] RES_FREED = 3'd3;
  localparam logic [2:0] RES_FREEZE = 3'd4;
  localparam logic [2:0] RES_NOTICE = 3'd5;
  localparam logic [2:0] RES_REMIND = 3'd6;

  localparam logic [7:0] COND_ANY = 8'h01;
  localparam logic [7:0] COND_CHANGED = 8'h02;
  localparam logic [7:0] COND_ABOVE = 8'h03;
  localparam logic [7:0] COND_BELOW = 8'h04;
  localparam logic [7:0] COND_EQUAL = 8'h05;
  localparam logic [7:0] COND_NOT_EQUAL = 8'h06;

  localparam logic [7:0] MAX_WATCH_BYTES = 8'd8;
  localparam logic [15:0] REMINDER_RESET = 16'd60;

  typedef struct packed {
    logic [3:0]  owner;
    logic [31:0] proc;
    logic [31:0] addr;
    logic [3:0]  size;
    logic [7:0]  cond;
    logic        kind;
    logic [63:0] compare;
  } ent_static_t;

  typedef struct packed {
    logic [63:0] previous;
    logic [31:0] stamp;
    logic [31:0] last_sent;
  } ent_dyn_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  entry;
    logic [31:0] proc;
    logic [31:0] addr;
    logic [3:0]  size;
    logic [63:0] value;
    logic [31:0] stamp;
  } res_t;

  function automatic logic cond_hit(input logic [7:0] cond, input logic [63:0] now,
                                    input logic [63:0] prev_v, input logic [63:0] ref_v);
    logic h;
    case (cond)
      COND_ANY: h = 1'b1;
      COND_CHANGED: h = now != prev_v;
      COND_ABOVE: h = now > ref_v;
      COND_BELOW: h = now < ref_v;
      COND_EQUAL: h = now == ref_v;
      COND_NOT_EQUAL: h = now != ref_v;
      default: h = 1'b0;
    endcase
    return h;
  endfunction
endpackage
`default_nettype wire

// ===== src/memory_watch_table_unit.sv =====
// top level: memory watch table with entry stores in synchronous memories
// tick, free and unknown request: result word the cycle after accept; sample: S_SEV,
// then S_OUT; add rejected on size: S_SCAN, then S_OUT; add: scan of valid bits, one entry
// a cycle, to a free entry or the table end; free by owner: S_ORD read, S_OEV check, per entry
// one item at a time, next word taken the cycle after the result word leaves
// reset clears valid bits and clock and loads interval from REMINDER_RESET; no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module memory_watch_table_unit #(
  parameter int TABLE_DEPTH = 64,
  parameter int OWNER_COUNT = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [3:0]  owner_i,
  input  wire logic [5:0]  entry_index_i,
  input  wire logic [31:0] proc_id_i,
  input  wire logic [31:0] watch_addr_i,
  input  wire logic [7:0]  byte_count_i,
  input  wire logic [7:0]  cond_code_i,
  input  wire logic        watch_kind_i,
  input  wire logic [63:0] data_value_i,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       res_kind_o,
  output logic [5:0]       res_entry_o,
  output logic [31:0]      res_proc_o,
  output logic [31:0]      res_addr_o,
  output logic [3:0]       res_size_o,
  output logic [63:0]      res_value_o,
  output logic [31:0]      res_stamp_o
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_SCAN = 6'b000010, S_ORD = 6'b000100,
    S_OEV = 6'b001000, S_SEV = 6'b010000, S_OUT = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [31:0] tick_q, tick_d;
  logic [15:0] interval_q;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [3:0] own_q;
  logic [5:0] idx_q;
  logic [31:0] proc_q, addr_q;
  logic [7:0] bytes_q, cond_q;
  logic kind_q;
  logic [63:0] data_q;
  mwt_pkg::res_t res_q, res_d;

  mwt_pkg::ent_static_t st_mem [TABLE_DEPTH];
  mwt_pkg::ent_dyn_t dy_mem [TABLE_DEPTH];
  mwt_pkg::ent_static_t st_rd_q;
  mwt_pkg::ent_dyn_t dy_rd_q;

  logic rd_en;
  logic [AW-1:0] rd_addr;
  logic st_we, dy_we;
  logic [AW-1:0] wr_addr;
  mwt_pkg::ent_static_t st_wd;
  mwt_pkg::ent_dyn_t dy_wd;

  logic accept;
  logic idx_ok, own_ok;
  logic hit;
  logic [31:0] since;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = state_q != S_IDLE;
  assign out_valid_o = state_q == S_OUT;
  assign idx_ok = 32'(idx_q) < 32'(TABLE_DEPTH);
  assign own_ok = 32'(own_q) < 32'(OWNER_COUNT);
  assign hit = mwt_pkg::cond_hit(st_rd_q.cond, data_q, dy_rd_q.previous, st_rd_q.compare);
  assign since = tick_q - dy_rd_q.last_sent;

  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[wr_addr] <= st_wd;
    if (dy_we) dy_mem[wr_addr] <= dy_wd;
    if (rd_en) begin
      st_rd_q <= st_mem[rd_addr];
      dy_rd_q <= dy_mem[rd_addr];
    end
  end

  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    tick_d = tick_q;
    ptr_d = ptr_q;
    res_d = res_q;
    rd_en = 1'b0;
    rd_addr = idx_q[AW-1:0];
    st_we = 1'b0;
    dy_we = 1'b0;
    wr_addr = ptr_q[AW-1:0];
    st_wd = '{owner: own_q, proc: proc_q, addr: addr_q, size: bytes_q[3:0], cond: cond_q,
              kind: kind_q, compare: data_q};
    dy_wd = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d = '0;
          ptr_d = '0;
          case (req_type_i)
            mwt_pkg::REQ_TICK: begin
              tick_d = tick_q + 32'd1;
              state_d = S_OUT;
            end
            mwt_pkg::REQ_ADD: state_d = S_SCAN;
            mwt_pkg::REQ_FREE: begin
              res_d.kind = mwt_pkg::RES_FREED;
              res_d.entry = entry_index_i;
              if (32'(entry_index_i) < 32'(TABLE_DEPTH))
                valid_d[entry_index_i[AW-1:0]] = 1'b0;
              state_d = S_OUT;
            end
            mwt_pkg::REQ_FREE_OWNER: state_d = S_ORD;
            mwt_pkg::REQ_SAMPLE: begin
              rd_en = 1'b1;
              rd_addr = entry_index_i[AW-1:0];
              state_d = S_SEV;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_SCAN: begin
        if (bytes_q > mwt_pkg::MAX_WATCH_BYTES || !own_ok ||
            ptr_q == CW'(TABLE_DEPTH)) begin
          res_d.kind = mwt_pkg::RES_REJECTED;
          state_d = S_OUT;
        end else if (!valid_q[ptr_q[AW-1:0]]) begin
          valid_d[ptr_q[AW-1:0]] = 1'b1;
          st_we = 1'b1;
          dy_we = 1'b1;
          res_d.kind = mwt_pkg::RES_ADDED;
          res_d.entry = 6'(ptr_q);
          res_d.size = bytes_q[3:0];
          state_d = S_OUT;
        end else begin
          ptr_d = ptr_q + CW'(1);
        end
      end
      S_ORD: begin
        if (!own_ok || ptr_q == CW'(TABLE_DEPTH)) begin
          state_d = S_OUT;
        end else begin
          rd_en = 1'b1;
          rd_addr = ptr_q[AW-1:0];
          state_d = S_OEV;
        end
      end
      S_OEV: begin
        if (valid_q[ptr_q[AW-1:0]] && st_rd_q.owner == own_q)
          valid_d[ptr_q[AW-1:0]] = 1'b0;
        ptr_d = ptr_q + CW'(1);
        state_d = S_ORD;
      end
      S_SEV: begin
        state_d = S_OUT;
        if (idx_ok && valid_q[idx_q[AW-1:0]] && st_rd_q.owner == own_q) begin
          wr_addr = idx_q[AW-1:0];
          dy_we = 1'b1;
          dy_wd = dy_rd_q;
          dy_wd.previous = data_q;
          if (hit && st_rd_q.kind) begin
            res_d.kind = mwt_pkg::RES_FREEZE;
            res_d.proc = st_rd_q.proc;
            res_d.addr = st_rd_q.addr;
            res_d.value = st_rd_q.compare;
          end else if (hit) begin
            dy_wd.stamp = tick_q;
            dy_wd.last_sent = tick_q;
            res_d.kind = mwt_pkg::RES_NOTICE;
            res_d.value = data_q;
            res_d.stamp = tick_q;
          end else if (!st_rd_q.kind && since > {16'd0, interval_q}) begin
            dy_wd.last_sent = tick_q;
            res_d.kind = mwt_pkg::RES_REMIND;
            res_d.value = data_q;
            res_d.stamp = dy_rd_q.stamp;
          end
          if (res_d.kind != mwt_pkg::RES_NONE) begin
            res_d.entry = idx_q;
            res_d.size = st_rd_q.size;
          end
        end
      end
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      tick_q <= '0;
      interval_q <= mwt_pkg::REMINDER_RESET;
      ptr_q <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      tick_q <= tick_d;
      ptr_q <= ptr_d;
      if (cfg_we_i) interval_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      own_q <= owner_i;
      idx_q <= entry_index_i;
      proc_q <= proc_id_i;
      addr_q <= watch_addr_i;
      bytes_q <= byte_count_i;
      cond_q <= cond_code_i;
      kind_q <= watch_kind_i;
      data_q <= data_value_i;
    end
  end

  assign res_kind_o = res_q.kind;
  assign res_entry_o = res_q.entry;
  assign res_proc_o = res_q.proc;
  assign res_addr_o = res_q.addr;
  assign res_size_o = res_q.size;
  assign res_value_o = res_q.value;
  assign res_stamp_o = res_q.stamp;
endmodule
`default_nettype wire

// ===== src/mwt_checker.sv =====
// checker: port-level properties of the memory watch table and its bind
`timescale 1ns / 1ps
`default_nettype none
module mwt_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [2:0] res_kind_o,
  input wire logic [3:0] res_size_o
);
  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("accept not followed by busy");
  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("new word taken while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(res_kind_o))
    else $error("stalled result changed");
  a_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> res_size_o <= 4'd8) else $error("result size above 8");
endmodule

bind memory_watch_table_unit mwt_checker u_mwt_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .res_kind_o(res_kind_o),
  .res_size_o(res_size_o)
);
`default_nettype wire
